// File: rtl/core/wssp_pkg.sv
// ---------------------------------------------------------------------------
// wssp_pkg: shared types and constants for the worst slack path selector
// Request and result payload structs, action and status codes.
// ---------------------------------------------------------------------------
package wssp_pkg;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_SETUP = 2'd1,
    ACT_HOLD  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_ENDS = 2'd1,
    ST_RANK    = 2'd2,
    ST_CHAIN   = 2'd3
  } status_t;

  localparam logic [2:0] KIND_PO      = 3'd1;
  localparam logic [2:0] KIND_CAPTURE = 3'd3;

  typedef struct packed {
    logic [1:0]         action;
    logic [5:0]         node_id;
    logic [2:0]         node_kind;
    logic signed [31:0] setup_slack;
    logic signed [31:0] hold_slack;
    logic signed [31:0] late_arrival;
    logic signed [31:0] early_arrival;
    logic [5:0]         setup_link;
    logic               has_setup_link;
    logic [5:0]         hold_link;
    logic               has_hold_link;
    logic [5:0]         rank;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [5:0]         path_node;
    logic [5:0]         hop;
    logic signed [31:0] path_slack;
    logic signed [31:0] path_delay;
    logic               last;
  } res_t;

  // one endpoint record travelling along the cell chain
  typedef struct packed {
    logic        vld;
    logic [5:0]  id;
    logic [31:0] key;   // slack with sign bit flipped, compares unsigned
  } ent_t;

endpackage

// File: rtl/core/wssp_cell.sv
// ---------------------------------------------------------------------------
// wssp_cell: one cell of the ranking chain
// Counts how many streamed endpoints order before the endpoint it holds.
// ---------------------------------------------------------------------------
module wssp_cell
  import wssp_pkg::*;
(
  input  logic clk,
  input  logic clr,     // start of a new pass
  input  ent_t own,     // this cell's endpoint, sampled during the load pass
  input  logic own_we,
  input  ent_t cmp_in,  // streamed neighbor data
  output ent_t cmp_out,
  output ent_t held,
  output logic [6:0] pos
);

  ent_t       held_r;
  ent_t       pass_r;
  logic [6:0] pos_r;
  logic       ahead;

  always_comb begin
    ahead = cmp_in.vld && held_r.vld && cmp_in.id != held_r.id &&
            ((cmp_in.key < held_r.key) ||
             (cmp_in.key == held_r.key && cmp_in.id < held_r.id));
  end

  always_ff @(posedge clk) begin
    pass_r <= cmp_in;
    if (clr) begin
      held_r.vld <= 1'b0;
      pos_r      <= '0;
    end else begin
      if (own_we) held_r <= own;
      if (ahead) pos_r <= pos_r + 7'd1;
    end
  end

  assign cmp_out = pass_r;
  assign held    = held_r;
  assign pos     = pos_r;

endmodule

// File: rtl/core/worst_slack_path_selector.sv
// ---------------------------------------------------------------------------
// worst_slack_path_selector: top-k worst slack endpoint and path backtrace
// Node table, ranking cell chain, link chase and path emit.
// ---------------------------------------------------------------------------
// channel  signals                   direction
// in       start/busy/in_req         request in, taken when start and !busy
// out      out_valid/out_res         one cycle strobe, no backpressure
// cfg      cfg_valid/cfg_ready/data  node_count write
//
// Loads never raise busy. A query (N = node_count capped at MAX_NODES) holds
// busy from accept to its last strobe: it scans the N table entries into the
// cells, streams them through the chain, picks the ranked cell, then chases
// the links one path node at a time and emits one result per path node; an
// error strobes from S_ERR after detection. Reset clears control and
// node_count only; the receiver cannot stall.
// ---------------------------------------------------------------------------
module worst_slack_path_selector
  import wssp_pkg::*;
#(
  parameter int MAX_NODES = 64
)(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  req_t       in_req,
  output logic       out_valid,
  output res_t       out_res,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_data
);

  localparam int IW = $clog2(MAX_NODES);
  localparam int CW = IW + 1;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SCAN  = 8'b0000_0010,
    S_STRM  = 8'b0000_0100,
    S_PICK  = 8'b0000_1000,
    S_RD    = 8'b0001_0000,
    S_CHK   = 8'b0010_0000,
    S_EMIT  = 8'b0100_0000,
    S_ERR   = 8'b1000_0000
  } state_t;

  // tables
  logic [2:0]  kind_mem  [MAX_NODES];
  logic [31:0] ss_mem    [MAX_NODES];
  logic [31:0] hs_mem    [MAX_NODES];
  logic [31:0] la_mem    [MAX_NODES];
  logic [31:0] ea_mem    [MAX_NODES];
  logic [6:0]  sl_mem    [MAX_NODES];
  logic [6:0]  hl_mem    [MAX_NODES];
  logic [5:0]  pbuf_mem  [MAX_NODES];

  state_t      state_r;
  logic [6:0]  ncount_r;
  logic        hold_r;
  logic [5:0]  rank_r;
  logic [CW:0] cnt_r;      // wide enough for 2*N stream steps
  logic [CW-1:0] ends_r;
  logic [IW-1:0] sel_r;
  logic [IW-1:0] cur_r;
  logic [CW-1:0] len_r;
  logic [CW-1:0] emit_r;
  logic [1:0]  err_r;
  logic        found_r;

  // registered table read port
  logic [IW-1:0] raddr;
  logic [2:0]    rd_kind_r;
  logic [31:0]   rd_ss_r, rd_hs_r, rd_la_r, rd_ea_r;
  logic [6:0]    rd_sl_r, rd_hl_r;
  logic [5:0]    rd_pb_r;
  logic [IW-1:0] rd_idx_r;
  logic          rd_vld_r;
  logic [CW-1:0] pb_raddr;

  logic [CW-1:0] n_eff;
  assign n_eff = (ncount_r > 7'(MAX_NODES)) ? CW'(MAX_NODES) : CW'(ncount_r);

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  // cell chain
  ent_t          chain [MAX_NODES+1];
  ent_t          held  [MAX_NODES];
  logic [6:0]    pos   [MAX_NODES];
  logic [MAX_NODES-1:0] match;
  ent_t          own_e;
  logic          cell_clr;
  logic          rd_ep;
  logic [31:0]   rd_key;

  assign rd_ep  = (rd_kind_r == KIND_CAPTURE) || (!hold_r && rd_kind_r == KIND_PO);
  assign rd_key = (hold_r ? rd_hs_r : rd_ss_r) ^ 32'h8000_0000;
  assign own_e  = '{vld: rd_vld_r && rd_ep, id: 6'(rd_idx_r), key: rd_key};
  assign cell_clr = (state_r == S_IDLE);

  // stream source: the table is read a second time, one entry per cycle
  assign chain[0] = (state_r == S_STRM) ? own_e : '0;

  for (genvar g = 0; g < MAX_NODES; g++) begin : g_cell
    wssp_cell u_cell (
      .clk     (clk),
      .clr     (cell_clr),
      .own     (own_e),
      .own_we  (rd_vld_r && state_r == S_SCAN && rd_idx_r == IW'(g)),
      .cmp_in  (chain[g]),
      .cmp_out (chain[g+1]),
      .held    (held[g]),
      .pos     (pos[g])
    );
    assign match[g] = held[g].vld && pos[g] == 7'(rank_r);
  end

  // pick cell, scanned one per cycle
  logic [IW-1:0] pk_idx;
  assign pk_idx = cnt_r[IW-1:0];

  always_comb begin
    raddr = cur_r;
    if (state_r == S_SCAN || state_r == S_STRM) raddr = cnt_r[IW-1:0];
  end
  assign pb_raddr = len_r - emit_r - CW'(1);

  always_ff @(posedge clk) begin
    if (start && !busy && in_req.action == ACT_LOAD &&
        {1'b0, in_req.node_id} < 7'(MAX_NODES)) begin
      kind_mem[in_req.node_id[IW-1:0]] <= in_req.node_kind;
      ss_mem[in_req.node_id[IW-1:0]]   <= in_req.setup_slack;
      hs_mem[in_req.node_id[IW-1:0]]   <= in_req.hold_slack;
      la_mem[in_req.node_id[IW-1:0]]   <= in_req.late_arrival;
      ea_mem[in_req.node_id[IW-1:0]]   <= in_req.early_arrival;
      sl_mem[in_req.node_id[IW-1:0]]   <= {in_req.has_setup_link, in_req.setup_link};
      hl_mem[in_req.node_id[IW-1:0]]   <= {in_req.has_hold_link, in_req.hold_link};
    end
    if (state_r == S_CHK && len_r < n_eff) pbuf_mem[len_r[IW-1:0]] <= 6'(cur_r);
    rd_kind_r <= kind_mem[raddr];
    rd_ss_r   <= ss_mem[raddr];
    rd_hs_r   <= hs_mem[raddr];
    rd_la_r   <= la_mem[raddr];
    rd_ea_r   <= ea_mem[raddr];
    rd_sl_r   <= sl_mem[raddr];
    rd_hl_r   <= hl_mem[raddr];
    rd_idx_r  <= raddr;
    rd_pb_r   <= pbuf_mem[pb_raddr[IW-1:0]];
  end

  logic [6:0] lk;
  assign lk = hold_r ? rd_hl_r : rd_sl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ncount_r  <= '0;
      out_valid <= 1'b0;
      rd_vld_r  <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      rd_vld_r  <= 1'b0;
      if (cfg_valid && cfg_ready) ncount_r <= cfg_data;
      case (state_r)
        S_IDLE: begin
          if (start && (in_req.action == ACT_SETUP || in_req.action == ACT_HOLD)) begin
            hold_r  <= (in_req.action == ACT_HOLD);
            rank_r  <= in_req.rank;
            cnt_r   <= '0;
            ends_r  <= '0;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          // table reads go out at cnt_r and land in the cells through the registered read port
          if (rd_vld_r && rd_ep) ends_r <= ends_r + CW'(1);
          if (cnt_r < (CW+1)'(n_eff)) begin
            rd_vld_r <= 1'b1;
            cnt_r    <= cnt_r + (CW+1)'(1);
          end else if (!rd_vld_r) begin
            cnt_r   <= '0;
            state_r <= S_STRM;
          end
        end
        S_STRM: begin
          // entries pass through every cell register on their way to the end of the chain
          if (cnt_r == (CW+1)'(2*MAX_NODES)) begin
            if (ends_r == '0) begin
              err_r <= ST_NO_ENDS; state_r <= S_ERR;
            end else if (CW'(rank_r) >= ends_r) begin
              err_r <= ST_RANK; state_r <= S_ERR;
            end else begin
              cnt_r   <= '0;
              found_r <= 1'b0;
              state_r <= S_PICK;
            end
          end else begin
            if (cnt_r < (CW+1)'(n_eff)) rd_vld_r <= 1'b1;
            cnt_r <= cnt_r + (CW+1)'(1);
          end
        end
        S_PICK: begin
          if (!found_r && match[pk_idx]) begin
            found_r <= 1'b1;
            sel_r   <= pk_idx;
            cur_r   <= pk_idx;
          end
          if (cnt_r == (CW+1)'(MAX_NODES-1)) begin
            if (found_r || match[pk_idx]) begin
              len_r   <= '0;
              state_r <= S_RD;
            end else begin
              err_r <= ST_RANK; state_r <= S_ERR;
            end
          end else begin
            cnt_r <= cnt_r + (CW+1)'(1);
          end
        end
        S_RD: begin
          // read of cur_r in flight
          if (len_r == '0 && cur_r == sel_r) begin
            // endpoint slack/delay are captured in S_CHK on the first read
          end
          state_r <= S_CHK;
        end
        S_CHK: begin
          if (len_r == '0) begin
            out_res.path_slack <= hold_r ? rd_hs_r : rd_ss_r;
            out_res.path_delay <= hold_r ? rd_ea_r : rd_la_r;
          end
          if (len_r >= n_eff) begin
            err_r <= ST_CHAIN; state_r <= S_ERR;
          end else begin
            len_r <= len_r + CW'(1);
            if (!lk[6]) begin
              emit_r  <= '0;
              state_r <= S_EMIT;
            end else if (CW'(lk[5:0]) >= n_eff) begin
              err_r <= ST_CHAIN; state_r <= S_ERR;
            end else begin
              cur_r   <= lk[IW-1:0];
              state_r <= S_RD;
            end
          end
        end
        S_EMIT: begin
          // pb read at len-1-emit is registered; each strobe follows a wait with rd_vld_r low
          if (rd_vld_r) begin
            out_valid         <= 1'b1;
            out_res.status    <= ST_OK;
            out_res.path_node <= rd_pb_r;
            out_res.hop       <= 6'(emit_r);
            out_res.last      <= (emit_r + CW'(1) == len_r);
            if (emit_r + CW'(1) == len_r) state_r <= S_IDLE;
            emit_r <= emit_r + CW'(1);
          end else begin
            rd_vld_r <= 1'b1;
          end
        end
        S_ERR: begin
          out_valid <= 1'b1;
          out_res   <= '{status: err_r, path_node: '0, hop: '0,
                         path_slack: '0, path_delay: '0, last: 1'b1};
          state_r   <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: test/worst_slack_path_selector_tb.sv
// ---------------------------------------------------------------------------
// worst_slack_path_selector_tb: self-checking bench for the path selector
// A directed table, then random phases of loads and setup/hold queries, with
// node_count changed between phases. Every path result is checked against a
// local model of the node table, endpoint ranking and link backtrace.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module worst_slack_path_selector_tb;
  import wssp_pkg::*;

  localparam int NODES      = 64;
  localparam int CYC_LIMIT  = 1000000;
  localparam int DRAIN_CYC  = 500;
  localparam int RAND_ITEMS = 230;

  typedef struct {
    bit         is_cfg;
    logic [6:0] cnt;
    req_t       req;
    bit         typed;
    status_t    st;
  } row_t;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  req_t       in_req;
  logic       out_valid;
  res_t       out_res;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [6:0] cfg_data;

  // local copy of the node table
  logic [2:0]         kind_mem  [NODES];
  logic signed [31:0] sslack_mem[NODES];
  logic signed [31:0] hslack_mem[NODES];
  logic signed [31:0] late_mem  [NODES];
  logic signed [31:0] early_mem [NODES];
  logic [6:0]         slink_mem [NODES];  // {valid, index}
  logic [6:0]         hlink_mem [NODES];
  logic [6:0]         node_cnt;

  res_t path_q[$];
  row_t rows[$];
  int   mismatches;
  int   cyc;
  int   burst_left;

  worst_slack_path_selector u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYC_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic void expect_res(res_t e);
    path_q = {path_q, e};
  endfunction

  function automatic void add_row(row_t w);
    rows = {rows, w};
  endfunction

  function automatic bit is_end(int i, bit hold);
    return kind_mem[i] == KIND_CAPTURE || (!hold && kind_mem[i] == KIND_PO);
  endfunction

  function automatic int used_nodes();
    return (node_cnt > NODES) ? NODES : int'(node_cnt);
  endfunction

  function automatic int count_ends(bit hold);
    int c;
    c = 0;
    for (int i = 0; i < used_nodes(); i++) if (is_end(i, hold)) c++;
    return c;
  endfunction

  function automatic res_t err_res(status_t st);
    res_t r;
    r = '0;
    r.status = st;
    r.last   = 1'b1;
    return r;
  endfunction

  // ranks endpoints, backtraces links and queues the expected path or error result
  function automatic void predict_path(req_t r);
    int  n, ends, sel, len, cur, pos;
    bit  hold, found;
    logic signed [31:0] sl_i, sl_j;
    logic [6:0] lk;
    int  trail[NODES];
    res_t e;
    n     = used_nodes();
    hold  = (r.action == ACT_HOLD);
    ends  = count_ends(hold);
    found = 0;
    sel   = 0;
    len   = 0;
    if (ends == 0) begin
      expect_res(err_res(ST_NO_ENDS));
      return;
    end
    if (int'(r.rank) >= ends) begin
      expect_res(err_res(ST_RANK));
      return;
    end
    for (int i = 0; i < n && !found; i++) begin
      if (!is_end(i, hold)) continue;
      pos  = 0;
      sl_i = hold ? hslack_mem[i] : sslack_mem[i];
      for (int j = 0; j < n; j++) begin
        if (j == i || !is_end(j, hold)) continue;
        sl_j = hold ? hslack_mem[j] : sslack_mem[j];
        if (sl_j < sl_i || (sl_j == sl_i && j < i)) pos++;
      end
      if (pos == int'(r.rank)) begin
        sel   = i;
        found = 1;
      end
    end
    cur = sel;
    forever begin
      if (len >= n) begin
        expect_res(err_res(ST_CHAIN));
        return;
      end
      trail[len++] = cur;
      lk = hold ? hlink_mem[cur] : slink_mem[cur];
      if (!lk[6]) break;
      cur = int'(lk[5:0]);
      if (cur >= n) begin
        expect_res(err_res(ST_CHAIN));
        return;
      end
    end
    for (int i = 0; i < len; i++) begin
      e            = '0;
      e.status     = ST_OK;
      e.path_node  = 6'(trail[len - 1 - i]);
      e.hop        = 6'(i);
      e.path_slack = hold ? hslack_mem[sel] : sslack_mem[sel];
      e.path_delay = hold ? early_mem[sel] : late_mem[sel];
      e.last       = (i == len - 1);
      expect_res(e);
    end
  endfunction

  function automatic void apply_request(req_t r);
    if (r.action == ACT_LOAD) begin
      kind_mem[r.node_id]   = r.node_kind;
      sslack_mem[r.node_id] = r.setup_slack;
      hslack_mem[r.node_id] = r.hold_slack;
      late_mem[r.node_id]   = r.late_arrival;
      early_mem[r.node_id]  = r.early_arrival;
      slink_mem[r.node_id]  = {r.has_setup_link, r.setup_link};
      hlink_mem[r.node_id]  = {r.has_hold_link, r.hold_link};
    end else if (r.action == ACT_SETUP || r.action == ACT_HOLD) begin
      predict_path(r);
    end
  endfunction

  // result checker; the block cannot be stalled so every strobe is a result
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (path_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_res);
      end else begin
        res_t e;
        e = path_q.pop_front();
        if (out_res.status !== e.status || out_res.path_node !== e.path_node ||
            out_res.hop !== e.hop || out_res.path_slack !== e.path_slack ||
            out_res.path_delay !== e.path_delay || out_res.last !== e.last) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch exp %p got %p", e, out_res);
        end
      end
    end
  end

  // sender pause; start stays high across back-to-back requests
  task automatic idle_gap();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(0, 8);
    end
  endtask

  task automatic send_request(req_t r, bit typed = 0, status_t st = ST_OK);
    in_req <= r;
    start  <= 1'b1;
    do @(posedge clk); while (busy);
    if (typed) expect_res(err_res(st));
    else apply_request(r);
    idle_gap();
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (path_q.size() != 0 || busy);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_count(logic [6:0] v);
    wait_idle();
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    node_cnt = v;
  endtask

  function automatic req_t rand_req();
    req_t r;
    logic [191:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    r = raw[$bits(req_t)-1:0];
    r.node_kind = 3'($urandom_range(0, 4));
    return r;
  endfunction

  // load biased toward well-formed chains pointing at lower ids
  function automatic req_t rand_load(int id);
    req_t r;
    r         = rand_req();
    r.action  = ACT_LOAD;
    r.node_id = 6'(id);
    if ($urandom_range(0, 9) != 0) begin
      r.setup_link     = (id > 0) ? 6'($urandom_range(0, id - 1)) : 6'd0;
      r.hold_link      = (id > 0) ? 6'($urandom_range(0, id - 1)) : 6'd0;
      r.has_setup_link = (id > 0) && ($urandom_range(0, 5) != 0);
      r.has_hold_link  = (id > 0) && ($urandom_range(0, 5) != 0);
    end
    return r;
  endfunction

  function automatic req_t mk_load(int id, logic [2:0] k, logic [31:0] ss,
                                   logic [31:0] hs, logic [31:0] la,
                                   logic [31:0] ea, logic [6:0] sl,
                                   logic [6:0] hl);
    req_t r;
    r = '0;
    r.action        = ACT_LOAD;
    r.node_id       = 6'(id);
    r.node_kind     = k;
    r.setup_slack   = ss;
    r.hold_slack    = hs;
    r.late_arrival  = la;
    r.early_arrival = ea;
    {r.has_setup_link, r.setup_link} = sl;
    {r.has_hold_link, r.hold_link}   = hl;
    return r;
  endfunction

  function automatic row_t mk_row(req_t r, bit typed = 0, status_t st = ST_OK);
    row_t w;
    w = '{is_cfg: 0, cnt: '0, req: r, typed: typed, st: st};
    return w;
  endfunction

  function automatic row_t mk_cfg(logic [6:0] v);
    row_t w;
    w = '{is_cfg: 1, cnt: v, req: '0, typed: 0, st: ST_OK};
    return w;
  endfunction

  function automatic req_t mk_query(action_t a, int rk);
    req_t r;
    r        = '0;
    r.action = a;
    r.rank   = 6'(rk);
    return r;
  endfunction

  initial begin
    req_t r;
    int   items, phase_len, ends;
    bit   hold;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_req     = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    node_cnt   = '0;
    burst_left = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, then a small graph with ties, cycles and
    // out-of-range links
    add_row(mk_row(mk_query(ACT_SETUP, 0), 1'b1, ST_NO_ENDS));
    add_row(mk_row(mk_query(ACT_HOLD, 0), 1'b1, ST_NO_ENDS));
    add_row(mk_row(mk_query(ACT_NONE, 0)));
    add_row(mk_row(mk_load(0, 3'd0, 32'h8000_0000, 32'h8000_0000,
                           32'h8000_0000, 32'h8000_0000, 7'h00, 7'h00)));
    add_row(mk_row(mk_load(1, 3'd4, 0, 0, 100, 50, 7'h40, 7'h40)));
    add_row(mk_row(mk_load(2, KIND_CAPTURE, 32'h8000_0000, 32'h7fff_ffff,
                           32'h7fff_ffff, 32'h8000_0000, 7'h41, 7'h41)));
    add_row(mk_row(mk_load(3, KIND_PO, 32'h8000_0000, 32'h8000_0000,
                           -5, 5, 7'h41, 7'h43)));
    add_row(mk_row(mk_load(4, KIND_CAPTURE, 32'h7fff_ffff, 32'h7fff_ffff,
                           32'hffff_ffff, 1, 7'h44, 7'h7f)));
    add_row(mk_row(mk_load(5, 3'd2, 1, 1, 1, 1, 7'h00, 7'h00)));
    add_row(mk_cfg(7'd5));
    add_row(mk_row(mk_query(ACT_SETUP, 0)));
    add_row(mk_row(mk_query(ACT_SETUP, 1)));
    add_row(mk_row(mk_query(ACT_SETUP, 2), 1'b1, ST_CHAIN));
    add_row(mk_row(mk_query(ACT_SETUP, 3), 1'b1, ST_RANK));
    add_row(mk_row(mk_query(ACT_SETUP, 63), 1'b1, ST_RANK));
    add_row(mk_row(mk_query(ACT_HOLD, 0)));
    add_row(mk_row(mk_query(ACT_HOLD, 1), 1'b1, ST_CHAIN));
    add_row(mk_row(mk_query(ACT_HOLD, 2), 1'b1, ST_RANK));
    add_row(mk_cfg(7'd1));
    add_row(mk_row(mk_query(ACT_SETUP, 0), 1'b1, ST_NO_ENDS));

    foreach (rows[i]) begin
      if (rows[i].is_cfg) write_count(rows[i].cnt);
      else send_request(rows[i].req, rows[i].typed, rows[i].st);
    end

    // fill the whole table so any node_count is safe to query
    for (int id = 6; id < NODES; id++) send_request(rand_load(id));
    write_count(7'd64);
    send_request(mk_query(ACT_SETUP, 0));
    send_request(mk_query(ACT_HOLD, 0));
    write_count(7'd127);
    send_request(mk_query(ACT_SETUP, 63));
    send_request(mk_query(ACT_HOLD, 1));

    items = 0;
    while (items < RAND_ITEMS) begin
      case ($urandom_range(0, 7))
        0:       write_count(7'd64);
        1:       write_count(7'd127);
        2:       write_count(7'd0);
        default: write_count(7'($urandom_range(1, 16)));
      endcase
      phase_len = $urandom_range(10, 30);
      for (int k = 0; k < phase_len && items < RAND_ITEMS; k++) begin
        case ($urandom_range(0, 9))
          0, 1, 2: r = rand_load($urandom_range(0, 63));
          3: begin
            r = rand_req();
            r.action = ACT_NONE;
          end
          default: begin
            r      = rand_req();
            hold   = 1'($urandom_range(0, 1));
            r.action = hold ? ACT_HOLD : ACT_SETUP;
            ends   = count_ends(hold);
            if (ends > 0 && $urandom_range(0, 4) != 0)
              r.rank = 6'($urandom_range(0, ends - 1));
          end
        endcase
        send_request(r);
        items++;
        if ($urandom_range(0, 40) == 0) wait_idle();
      end
    end

    wait_idle();
    repeat (DRAIN_CYC) @(posedge clk);
    if (mismatches == 0 && path_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: worst_slack_path_selector.f
rtl/core/wssp_pkg.sv
rtl/core/wssp_cell.sv
rtl/core/worst_slack_path_selector.sv
test/worst_slack_path_selector_tb.sv
